// File: rtl/x86_control_register_unit_macros.svh
// Assertion helpers for the control register unit.
// Both sample on clk and are off while rst_n is low.
`ifndef X86_CONTROL_REGISTER_UNIT_MACROS_SVH
`define X86_CONTROL_REGISTER_UNIT_MACROS_SVH

// Same-cycle implication.
`define CRU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("control register unit: same-cycle check failed");

// Next-cycle implication.
`define CRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("control register unit: next-cycle check failed");

`endif

// File: rtl/cru_pkg.sv
`default_nettype none

package cru_pkg;

  // access kinds
  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_LMSW  = 3'd2;
  localparam logic [2:0] ACT_CLTS  = 3'd3;
  localparam logic [2:0] ACT_SMSW  = 3'd4;

  // control register numbers
  localparam logic [2:0] CR_IDX_0 = 3'd0;
  localparam logic [2:0] CR_IDX_2 = 3'd2;
  localparam logic [2:0] CR_IDX_3 = 3'd3;
  localparam logic [2:0] CR_IDX_4 = 3'd4;

  // fault codes
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_GP   = 2'd1;
  localparam logic [1:0] FAULT_UD   = 2'd2;

  // CR0 bit positions
  localparam int CR0_PE_BIT = 0;
  localparam int CR0_TS_BIT = 3;
  localparam int CR0_ET_BIT = 4;
  localparam int CR0_NW_BIT = 29;
  localparam int CR0_CD_BIT = 30;
  localparam int CR0_PG_BIT = 31;

  localparam logic [31:0] CR0_MASK     = 32'he005003f;
  localparam logic [31:0] CR3_MASK     = 32'hfffff018;
  localparam logic [31:0] CR4_RESERVED = 32'hfffffc00;
  localparam int          CR4_W        = 10;
  localparam logic [CR4_W-1:0] CR4_TLB_BITS = 10'h0b0;
  localparam logic [31:0] MSW_BITS     = 32'h0000000f;

  localparam logic FPU_PRESENT_RST = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  cr_index;
    logic        register_form;
    logic [31:0] data;
    logic        protected_mode;
    logic        vm86;
    logic [1:0]  cpl;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  fault;
    logic        flush_tlb;
    logic        enter_protected;
    logic        leave_protected;
    logic        paging_on;
    logic        paging_off;
  } result_t;

  typedef struct packed {
    logic [31:0]      cr0;
    logic [31:0]      cr2;
    logic [31:0]      cr3;
    logic [CR4_W-1:0] cr4;
  } cr_state_t;

endpackage

`default_nettype wire

// File: rtl/cru_exec.sv
`default_nettype none

// Single-pass execute: checks, result and next register contents.
module cru_exec (
  input  wire cru_pkg::item_t     item,
  input  wire cru_pkg::cr_state_t st,
  input  wire                     fpu_present,
  output cru_pkg::result_t        res,
  output cru_pkg::cr_state_t      st_nxt
);

  logic        mov_bad;
  logic        msw_bad;
  logic [31:0] cr0_new;
  logic [31:0] cr0_chg;
  logic        cr0_refused;
  logic [31:0] lmsw_new;

  assign mov_bad = item.protected_mode && (item.vm86 || (item.cpl != 2'd0));
  assign msw_bad = item.protected_mode && (item.cpl != 2'd0);

  assign cr0_refused =
    (item.data[cru_pkg::CR0_PG_BIT] && !item.data[cru_pkg::CR0_PE_BIT]) ||
    (item.data[cru_pkg::CR0_NW_BIT] && !item.data[cru_pkg::CR0_CD_BIT]);

  always_comb begin
    cr0_new = item.data & cru_pkg::CR0_MASK;
    cr0_new[cru_pkg::CR0_ET_BIT] = fpu_present;
  end

  assign cr0_chg = st.cr0 ^ cr0_new;

  // PE may be set but never cleared by LMSW
  assign lmsw_new = (st.cr0 & ~cru_pkg::MSW_BITS) | (item.data & cru_pkg::MSW_BITS)
                  | (st.cr0 & 32'h1);

  always_comb begin
    res    = '0;
    st_nxt = st;
    case (item.action)
      cru_pkg::ACT_WRITE: begin
        if (!item.register_form) begin
          res.fault = cru_pkg::FAULT_UD;
        end else if (mov_bad) begin
          res.fault = cru_pkg::FAULT_GP;
        end else begin
          case (item.cr_index)
            cru_pkg::CR_IDX_0: begin
              if (cr0_refused) begin
                res.fault = cru_pkg::FAULT_GP;
              end else begin
                st_nxt.cr0          = cr0_new;
                res.flush_tlb       = cr0_chg[cru_pkg::CR0_PE_BIT] ||
                                      cr0_chg[cru_pkg::CR0_PG_BIT];
                res.enter_protected = cr0_chg[cru_pkg::CR0_PE_BIT] &&
                                      cr0_new[cru_pkg::CR0_PE_BIT];
                res.leave_protected = cr0_chg[cru_pkg::CR0_PE_BIT] &&
                                      !cr0_new[cru_pkg::CR0_PE_BIT];
                res.paging_on       = cr0_chg[cru_pkg::CR0_PG_BIT] &&
                                      cr0_new[cru_pkg::CR0_PG_BIT];
                res.paging_off      = cr0_chg[cru_pkg::CR0_PG_BIT] &&
                                      !cr0_new[cru_pkg::CR0_PG_BIT];
              end
            end
            cru_pkg::CR_IDX_2: begin
              st_nxt.cr2 = item.data;
            end
            cru_pkg::CR_IDX_3: begin
              st_nxt.cr3    = item.data & cru_pkg::CR3_MASK;
              res.flush_tlb = 1'b1;
            end
            cru_pkg::CR_IDX_4: begin
              if ((item.data & cru_pkg::CR4_RESERVED) != 32'd0) begin
                res.fault = cru_pkg::FAULT_GP;
              end else begin
                st_nxt.cr4    = item.data[cru_pkg::CR4_W-1:0];
                res.flush_tlb = ((st.cr4 ^ item.data[cru_pkg::CR4_W-1:0])
                                 & cru_pkg::CR4_TLB_BITS) != '0;
              end
            end
            default: begin
              res.fault = cru_pkg::FAULT_UD;
            end
          endcase
        end
      end
      cru_pkg::ACT_READ: begin
        if (!item.register_form) begin
          res.fault = cru_pkg::FAULT_UD;
        end else if (mov_bad) begin
          res.fault = cru_pkg::FAULT_GP;
        end else begin
          case (item.cr_index)
            cru_pkg::CR_IDX_0: res.read_data = st.cr0;
            cru_pkg::CR_IDX_2: res.read_data = st.cr2;
            cru_pkg::CR_IDX_3: res.read_data = st.cr3;
            cru_pkg::CR_IDX_4: res.read_data = {{(32-cru_pkg::CR4_W){1'b0}}, st.cr4};
            default:           res.fault     = cru_pkg::FAULT_UD;
          endcase
        end
      end
      cru_pkg::ACT_LMSW: begin
        if (msw_bad) begin
          res.fault = cru_pkg::FAULT_GP;
        end else begin
          st_nxt.cr0          = lmsw_new;
          res.enter_protected = !st.cr0[cru_pkg::CR0_PE_BIT] &&
                                lmsw_new[cru_pkg::CR0_PE_BIT];
        end
      end
      cru_pkg::ACT_CLTS: begin
        if (msw_bad) begin
          res.fault = cru_pkg::FAULT_GP;
        end else begin
          st_nxt.cr0[cru_pkg::CR0_TS_BIT] = 1'b0;
        end
      end
      cru_pkg::ACT_SMSW: begin
        res.read_data = st.cr0;
      end
      default: begin
        res.fault = cru_pkg::FAULT_UD;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/cru_regfile.sv
`default_nettype none

// CR0/CR2/CR3/CR4 storage, loaded when an item executes.
module cru_regfile (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     load,
  input  wire cru_pkg::cr_state_t st_nxt,
  output cru_pkg::cr_state_t      st
);

  cru_pkg::cr_state_t st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (load) begin
      st_r <= st_nxt;
    end
  end

  assign st = st_r;

endmodule

`default_nettype wire

// File: rtl/x86_control_register_unit.sv
// Control register unit: CR0, CR2, CR3, CR4 and the MOV CR, LMSW, CLTS,
// SMSW accesses.
// Input channel in_*: one access per transfer (in_valid high, in_stall low).
// Result channel out_*: exactly one result per access, in order; fault
//   codes 0 none, 1 #GP, 2 #UD / bad register, with all other fields zero
//   on a fault.
// Config: cfg_wr_en/cfg_wr_data load fpu_present (forces CR0.ET on CR0
//   moves); write it only while the unit is idle.
// Pipeline: an access passes the input register, then executes into the
//   result register and the control registers.
// Throughput: one access per cycle, back to back, unless out_stall holds;
//   an access sees the register contents left by the one before it with no
//   bubble, as the register file loads in the same cycle as the result.
// Stall: when out_stall holds a valid result, the input stage keeps its
//   access and in_stall rises only if that stage is full; a result is
//   never dropped and registers change only when an access executes.
// Reset (rst_n low, synchronous): both stages empty, CR0/CR2/CR3/CR4
//   cleared, fpu_present set to 1.
`default_nettype none

module x86_control_register_unit (
  input  wire        clk,
  input  wire        rst_n,

  input  wire        cfg_wr_en,
  input  wire        cfg_wr_data,

  input  wire        in_valid,
  output logic       in_stall,
  input  wire [2:0]  in_action,
  input  wire [2:0]  in_cr_index,
  input  wire        in_register_form,
  input  wire [31:0] in_data,
  input  wire        in_protected_mode,
  input  wire        in_vm86,
  input  wire [1:0]  in_cpl,

  output logic       out_valid,
  input  wire        out_stall,
  output logic [31:0] out_read_data,
  output logic [1:0] out_fault,
  output logic       out_flush_tlb,
  output logic       out_enter_protected,
  output logic       out_leave_protected,
  output logic       out_paging_on,
  output logic       out_paging_off
);

`include "x86_control_register_unit_macros.svh"

  // configuration
  logic fpu_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpu_present_r <= cru_pkg::FPU_PRESENT_RST;
    end else if (cfg_wr_en) begin
      fpu_present_r <= cfg_wr_data;
    end
  end

  // input stage
  logic              in_valid_r;
  cru_pkg::item_t    item_r;
  logic              exec_go;
  logic              in_take;

  // result stage
  logic              out_valid_r;
  cru_pkg::result_t  res_r;
  cru_pkg::result_t  res_nxt;

  cru_pkg::cr_state_t st;
  cru_pkg::cr_state_t st_nxt;

  // execute when the result register is free or being drained this cycle
  assign exec_go  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !exec_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (exec_go) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{action:         in_action,
                  cr_index:       in_cr_index,
                  register_form:  in_register_form,
                  data:           in_data,
                  protected_mode: in_protected_mode,
                  vm86:           in_vm86,
                  cpl:            in_cpl};
    end
  end

  cru_exec u_exec (
    .item        (item_r),
    .st          (st),
    .fpu_present (fpu_present_r),
    .res         (res_nxt),
    .st_nxt      (st_nxt)
  );

  cru_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (exec_go),
    .st_nxt (st_nxt),
    .st     (st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = res_r.read_data;
  assign out_fault           = res_r.fault;
  assign out_flush_tlb       = res_r.flush_tlb;
  assign out_enter_protected = res_r.enter_protected;
  assign out_leave_protected = res_r.leave_protected;
  assign out_paging_on       = res_r.paging_on;
  assign out_paging_off      = res_r.paging_off;

  // a faulting result carries nothing else
  `CRU_ASSERT_IMP(a_fault_clean, out_valid_r && (res_r.fault != cru_pkg::FAULT_NONE),
    (res_r.read_data == 32'd0) && !res_r.flush_tlb && !res_r.enter_protected &&
    !res_r.leave_protected && !res_r.paging_on && !res_r.paging_off)
  // stored CR0 never holds PG without PE or NW without CD
  `CRU_ASSERT_IMP(a_cr0_legal, 1'b1,
    (!st.cr0[cru_pkg::CR0_PG_BIT] || st.cr0[cru_pkg::CR0_PE_BIT]) &&
    (!st.cr0[cru_pkg::CR0_NW_BIT] || st.cr0[cru_pkg::CR0_CD_BIT]))
  // a stalled result register keeps its item when nothing executes
  `CRU_ASSERT_NEXT(a_res_hold, out_valid_r && out_stall, out_valid_r && $stable(res_r))
  // mode switch flags are exclusive
  `CRU_ASSERT_IMP(a_flags_excl, out_valid_r,
    !(res_r.enter_protected && res_r.leave_protected) &&
    !(res_r.paging_on && res_r.paging_off))

endmodule

`default_nettype wire
